### rtl/apblend_pkg.sv
package apblend_pkg;

	typedef logic [7:0]  lane_t;
	typedef logic [15:0] wide_t;
	typedef logic [31:0] pixel_t;
	typedef logic [1:0]  mode_t;

	localparam int unsigned LANES = 4;
	localparam int unsigned LANE_W = 8;

	localparam mode_t MODE_SRC_ALPHA = 2'd0;
	localparam mode_t MODE_SCALED    = 2'd1;
	localparam mode_t MODE_KEEP_BASE = 2'd2;
	localparam mode_t MODE_CONSTANT  = 2'd3;

	localparam lane_t  OPACITY_RESET = 8'hFF;
	localparam pixel_t OPAQUE_MIN    = 32'hFF00_0000;

endpackage

### rtl/apblend_if.sv
interface apblend_px_if;
	logic                 valid;
	logic                 ready;
	apblend_pkg::mode_t   mode;
	apblend_pkg::pixel_t  base_pixel;
	apblend_pkg::pixel_t  over_pixel;
	logic                 last_in;

	modport source (output valid, mode, base_pixel, over_pixel, last_in, input ready);
	modport sink (input valid, mode, base_pixel, over_pixel, last_in, output ready);
endinterface

interface apblend_res_if;
	logic                 valid;
	logic                 ready;
	apblend_pkg::pixel_t  blended_pixel;
	logic                 last_out;

	modport source (output valid, blended_pixel, last_out, input ready);
	modport sink (input valid, blended_pixel, last_out, output ready);
endinterface

interface apblend_cfg_if;
	logic                 valid;
	logic                 ready;
	apblend_pkg::lane_t   opacity;

	modport source (output valid, opacity, input ready);
	modport sink (input valid, opacity, output ready);
endinterface

### rtl/argb_pixel_alpha_blend.sv
// Channel  Dir  Payload                                     Transfer
// pix      in   mode, base_pixel, over_pixel, last_in       valid && ready
// res      out  blended_pixel, last_out                     valid && ready
// cfg      in   opacity                                     valid && ready (always ready)
//
// One pixel per cycle while res is ready; a pixel taken on pix passes the stage 1, 2 and 3 registers before res.
// Stage 1 forms opacity times the over pixel, stage 2 the lane differences
// and lane products, stage 3 the lane sums and the output register.
// Reset empties the pipeline and sets opacity to 255.
// A stage advances when the stage after it is empty or advancing, so a stall
// on res holds every pixel in place while bubbles ahead of it are filled.
module argb_pixel_alpha_blend (
	input  logic               clk,
	input  logic               arst_n,
	apblend_px_if.sink         pix,
	apblend_res_if.source      res,
	apblend_cfg_if.sink        cfg
);
	import apblend_pkg::*;

	lane_t  opacity_q;

	logic   v_s1, v_s2, v_s3;
	logic   en1, en2, en3;

	mode_t  mode_s1;
	pixel_t base_s1;
	pixel_t over_s1;
	lane_t  alpha_sc_s1;
	logic   last_s1;

	mode_t  mode_s2;
	pixel_t over_s2;
	lane_t  base_a_s2;
	logic   last_s2;

	pixel_t blended_s3;
	logic   last_s3;

	logic [39:0] scale_prod;
	lane_t  a_sel;
	pixel_t mix;

	assign en3 = !v_s3 || res.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pix.ready = en1;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opacity_q <= OPACITY_RESET;
		end else if (cfg.valid) begin
			opacity_q <= cfg.opacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pix.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	assign scale_prod = {32'd0, opacity_q} * {8'd0, pix.over_pixel};

	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1     <= pix.mode;
			base_s1     <= pix.base_pixel;
			over_s1     <= pix.over_pixel;
			alpha_sc_s1 <= scale_prod[39:32];
			last_s1     <= pix.last_in;
		end
	end

	always_comb begin
		case (mode_s1)
			MODE_SCALED:   a_sel = alpha_sc_s1;
			MODE_CONSTANT: a_sel = opacity_q;
			default:       a_sel = over_s1[31:24];
		endcase
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		apblend_lane u_lane (
			.clk (clk),
			.en  (en2),
			.b   (base_s1[k*LANE_W +: LANE_W]),
			.o   (over_s1[k*LANE_W +: LANE_W]),
			.a   (a_sel),
			.mix (mix[k*LANE_W +: LANE_W])
		);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			mode_s2   <= mode_s1;
			over_s2   <= over_s1;
			base_a_s2 <= base_s1[31:24];
			last_s2   <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			last_s3 <= last_s2;
			if (mode_s2 == MODE_SRC_ALPHA && over_s2 >= OPAQUE_MIN) begin
				blended_s3 <= over_s2;
			end else if (mode_s2 == MODE_KEEP_BASE) begin
				blended_s3 <= {base_a_s2, mix[23:0]};
			end else begin
				blended_s3 <= mix;
			end
		end
	end

	assign res.valid         = v_s3;
	assign res.blended_pixel = blended_s3;
	assign res.last_out      = last_s3;

	a_opaque_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(en3 && v_s2 && mode_s2 == MODE_SRC_ALPHA && over_s2 >= OPAQUE_MIN)
		|=> (res.blended_pixel == $past(over_s2)))
		else $error("opaque over pixel not passed through");

	a_keep_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(en3 && v_s2 && mode_s2 == MODE_KEEP_BASE)
		|=> (res.blended_pixel[31:24] == $past(base_a_s2)))
		else $error("base alpha not kept");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en2) |=> (v_s1 && $stable(over_s1) && $stable(base_s1)))
		else $error("stage 1 changed while stalled");

	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s3 |-> pix.ready)
		else $error("input not ready with an empty output stage");

endmodule

### rtl/apblend_lane.sv
module apblend_lane (
	input  logic                clk,
	input  logic                en,
	input  apblend_pkg::lane_t  b,
	input  apblend_pkg::lane_t  o,
	input  apblend_pkg::lane_t  a,
	output apblend_pkg::lane_t  mix
);
	import apblend_pkg::*;

	wide_t d;
	wide_t p;
	lane_t b_s2;
	wide_t p_s2;

	// The difference wraps at 16 bits, so a base above the over value
	// gives a large positive word rather than a negative one.
	assign d = {8'd0, o} - {8'd0, b};
	assign p = wide_t'(d * {8'd0, a});

	always_ff @(posedge clk) begin
		if (en) begin
			b_s2 <= b;
			p_s2 <= p;
		end
	end

	// Both lane formulas reduce to the base plus the top byte of the
	// product, since the shifted base has nothing in its low byte.
	assign mix = b_s2 + p_s2[15:8];

endmodule

### tb/tb_argb_pixel_alpha_blend.sv
module tb_argb_pixel_alpha_blend;
	import apblend_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned ITEMS_PER_SEGMENT = 208;
	localparam int unsigned N_DIRECTED = 21;

	typedef struct packed {
		pixel_t px;
		logic   last;
	} blend_result_t;

	typedef struct packed {
		bit     set_opac;
		lane_t  opac;
		mode_t  mode;
		pixel_t base_px;
		pixel_t over_px;
		logic   last;
		bit     has_want;
		pixel_t want_px;
	} pixel_vector_t;

	// Rows with a typed result are the ones that can be read off directly: opaque
	// pass-through, a zero blend factor and equal pixels all leave a known pixel.
	localparam pixel_vector_t DIRECTED [N_DIRECTED] = '{
		'{1'b0, 8'h00, MODE_SRC_ALPHA, 32'h1234_5678, 32'hFF00_0000, 1'b0, 1'b1, 32'hFF00_0000},
		'{1'b0, 8'h00, MODE_SRC_ALPHA, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 8'h00, MODE_SRC_ALPHA, 32'hFFFF_FFFF, 32'h00AB_CDEF, 1'b0, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 8'h00, MODE_SRC_ALPHA, 32'h0000_0000, 32'hFEFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{1'b0, 8'h00, MODE_SRC_ALPHA, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
		'{1'b0, 8'h00, MODE_SCALED,    32'h89AB_CDEF, 32'h0000_0000, 1'b0, 1'b1, 32'h89AB_CDEF},
		'{1'b0, 8'h00, MODE_SCALED,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{1'b0, 8'h00, MODE_SCALED,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 8'h00, MODE_KEEP_BASE, 32'hA500_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{1'b0, 8'h00, MODE_KEEP_BASE, 32'h5A12_3456, 32'h00FF_FFFF, 1'b0, 1'b1, 32'h5A12_3456},
		'{1'b0, 8'h00, MODE_CONSTANT,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{1'b0, 8'h00, MODE_CONSTANT,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
		'{1'b0, 8'h00, MODE_CONSTANT,  32'h3C3C_3C3C, 32'h3C3C_3C3C, 1'b0, 1'b1, 32'h3C3C_3C3C},
		'{1'b1, 8'h00, MODE_CONSTANT,  32'h1357_9BDF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h1357_9BDF},
		'{1'b0, 8'h00, MODE_SCALED,    32'h2468_ACE0, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h2468_ACE0},
		'{1'b0, 8'h00, MODE_SRC_ALPHA, 32'h0000_0000, 32'h7F80_8080, 1'b0, 1'b0, 32'h0},
		'{1'b0, 8'h00, MODE_KEEP_BASE, 32'hFF00_FF00, 32'h8000_FF00, 1'b1, 1'b0, 32'h0},
		'{1'b1, 8'hFF, MODE_SCALED,    32'hFFFF_FFFF, 32'h0102_0304, 1'b0, 1'b0, 32'h0},
		'{1'b0, 8'h00, MODE_CONSTANT,  32'h8080_8080, 32'h7F7F_7F7F, 1'b1, 1'b0, 32'h0},
		'{1'b1, 8'h01, MODE_CONSTANT,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{1'b0, 8'h00, MODE_SCALED,    32'h00FF_00FF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h00FF_00FF}
	};

	logic clk = 1'b0;
	logic arst_n;

	apblend_px_if  pix_ch ();
	apblend_res_if res_ch ();
	apblend_cfg_if cfg_ch ();

	argb_pixel_alpha_blend u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	blend_result_t pending_blends [$];
	lane_t         opacity_model;
	int unsigned   send_idle_pct;
	int unsigned   recv_idle_pct;
	int unsigned   pixels_sent;
	int unsigned   results_checked;
	int unsigned   opacity_writes;
	int unsigned   mismatches;
	int unsigned   cycle_count = 0;

	always #2 clk = ~clk;

	// Blend one base/over pair the way the block should, lane by lane in
	// 16-bit wrapping arithmetic.
	function automatic pixel_t blended_argb(mode_t mode, pixel_t base_px, pixel_t over_px,
			lane_t opac);
		logic [63:0] scaled;
		logic [15:0] diff;
		logic [15:0] mix;
		lane_t       factor;
		lane_t       b;
		lane_t       o;
		pixel_t      out_px;
		int          n_lanes;

		factor = over_px[31:24];
		n_lanes = LANES;
		out_px = '0;
		case (mode)
			MODE_SRC_ALPHA: begin
				if (over_px >= OPAQUE_MIN)
					return over_px;
			end
			MODE_SCALED: begin
				scaled = 64'(opac) * 64'(over_px);
				factor = scaled[39:32];
			end
			MODE_KEEP_BASE: begin
				n_lanes = LANES - 1;
				out_px[31:24] = base_px[31:24];
			end
			default: factor = opac;
		endcase
		for (int k = 0; k < n_lanes; k++) begin
			b = base_px[LANE_W*k +: LANE_W];
			o = over_px[LANE_W*k +: LANE_W];
			diff = {8'h00, o} - {8'h00, b};
			if (mode == MODE_SRC_ALPHA) begin
				mix = diff * {8'h00, factor};
				out_px[LANE_W*k +: LANE_W] = b + mix[15:8];
			end else begin
				mix = {b, 8'h00} + diff * {8'h00, factor};
				out_px[LANE_W*k +: LANE_W] = mix[15:8];
			end
		end
		return out_px;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s on result %0d: got %h, expected %h",
			what, results_checked, got, want);
		mismatches++;
	endtask

	task automatic send_pixel(mode_t mode, pixel_t base_px, pixel_t over_px, logic last,
			bit has_want, pixel_t want_px);
		blend_result_t due;

		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid      <= 1'b1;
		pix_ch.mode       <= mode;
		pix_ch.base_pixel <= base_px;
		pix_ch.over_pixel <= over_px;
		pix_ch.last_in    <= last;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		due.px = has_want ? want_px : blended_argb(mode, base_px, over_px, opacity_model);
		due.last = last;
		pending_blends.push_back(due);
		pixels_sent++;
	endtask

	task automatic drain_pipeline();
		pix_ch.valid <= 1'b0;
		while (pending_blends.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_opacity(lane_t value);
		drain_pipeline();
		cfg_ch.valid   <= 1'b1;
		cfg_ch.opacity <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		opacity_model = value;
		opacity_writes++;
	endtask

	task automatic send_random_pixel();
		mode_t  mode;
		pixel_t base_px;
		pixel_t over_px;
		logic   last;

		mode = mode_t'($urandom_range(0, 3));
		base_px = $urandom;
		over_px = $urandom;
		last = ($urandom_range(0, 7) == 0);
		case ($urandom_range(0, 15))
			0, 1, 2, 3: over_px[31:24] = 8'hFF;
			4: over_px = base_px;
			5: over_px[31:24] = 8'h00;
			6: base_px = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			7: over_px = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			default: ;
		endcase
		send_pixel(mode, base_px, over_px, last, 1'b0, '0);
	endtask

	// Result side: checks every transaction against the oldest prediction and
	// then decides whether to stall the next cycle.
	initial begin
		blend_result_t due;

		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (pending_blends.size() == 0) begin
					report_mismatch("unexpected result", res_ch.blended_pixel, '0);
				end else begin
					due = pending_blends.pop_front();
					if (res_ch.blended_pixel !== due.px)
						report_mismatch("blended_pixel", res_ch.blended_pixel, due.px);
					if (res_ch.last_out !== due.last)
						report_mismatch("last_out", 32'(res_ch.last_out), 32'(due.last));
				end
				results_checked++;
			end
			res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, pending_blends.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		lane_t opac_plan [6];

		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.mode = MODE_SRC_ALPHA;
		pix_ch.base_pixel = '0;
		pix_ch.over_pixel = '0;
		pix_ch.last_in = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.opacity = OPACITY_RESET;
		opacity_model = OPACITY_RESET;
		pixels_sent = 0;
		results_checked = 0;
		opacity_writes = 0;
		mismatches = 0;
		send_idle_pct = 11;
		recv_idle_pct = 87;
		opac_plan = '{8'h01, 8'h80, 8'h00, 8'hAA, 8'h55, 8'hFE};
		opac_plan[2] = $urandom_range(2, 253);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first rows run with the opacity left at its reset value.
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].set_opac)
				set_opacity(DIRECTED[i].opac);
			send_pixel(DIRECTED[i].mode, DIRECTED[i].base_px, DIRECTED[i].over_px,
				DIRECTED[i].last, DIRECTED[i].has_want, DIRECTED[i].want_px);
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 87 : 0;
			recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 11 : 0;
			for (int seg = 0; seg < 2; seg++) begin
				set_opacity(opac_plan[phase*2 + seg]);
				repeat (ITEMS_PER_SEGMENT) send_random_pixel();
			end
		end

		drain_pipeline();
		$display("Blended %0d pixels (%0d directed) in all four modes, %0d results checked,",
			pixels_sent, N_DIRECTED, results_checked);
		$display("under %0d opacity writes and three stall patterns; %0d mismatches",
			opacity_writes, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### argb_pixel_alpha_blend.f
rtl/apblend_pkg.sv
rtl/apblend_if.sv
rtl/apblend_lane.sv
rtl/argb_pixel_alpha_blend.sv
tb/tb_argb_pixel_alpha_blend.sv
